// ----- sv/bud_pkg.sv -----
// Shared types and constants for the bit unpacking dequantizer.
// No dependencies; used by every module of the block by scoped name.
package bud_pkg;

    localparam int BYTE_BITS      = 8;
    localparam int MAX_CODE_WIDTH = 16;
    localparam int BUF_BITS       = MAX_CODE_WIDTH - 1 + BYTE_BITS;
    localparam int HELD_W         = $clog2(BUF_BITS + 1);
    localparam int CODE_W         = 16;
    localparam int WIDTH_W        = 5;
    localparam int CFG_DATA_W     = 32;
    localparam int PROD_W         = CODE_W + CFG_DATA_W;
    localparam int VALUE_W        = 50;
    localparam int CODES_PER_BYTE = BYTE_BITS;
    localparam int BYTE_CNT_W     = $clog2(CODES_PER_BYTE);

    typedef enum logic [1:0] {
        REG_CODE_WIDTH   = 2'd0,
        REG_VALUE_COUNT  = 2'd1,
        REG_VALUE_OFFSET = 2'd2,
        REG_STEP_SIZE    = 2'd3
    } cfg_reg_t;

    // One unpacked code on its way from the front to the back.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last_in_byte;
        logic              stream_end;
    } entry_t;

    // Settings the back end reads while it scales codes.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] value_offset;
        logic [CFG_DATA_W-1:0] step_size;
    } scale_cfg_t;

endpackage

// ----- sv/bud_front.sv -----
// Front end: takes packed bytes, holds the bit buffer and code counter,
// and splits out one code per cycle while the queue has room. Depends on bud_pkg.
module bud_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [bud_pkg::BYTE_BITS-1:0]         data_byte,
    input  logic [bud_pkg::WIDTH_W-1:0]           width,
    input  logic [bud_pkg::CFG_DATA_W-1:0]        value_count,
    output logic                                  q_push,
    input  logic                                  q_full,
    output bud_pkg::entry_t                       q_entry
);

    logic [bud_pkg::BUF_BITS-1:0]       buf_reg, buf_next;
    logic [bud_pkg::HELD_W-1:0]         held_reg, held_next;
    logic [bud_pkg::CFG_DATA_W-1:0]     cnt_reg, cnt_next;
    logic [bud_pkg::BYTE_CNT_W-1:0]     n_reg, n_next;
    logic                               pend_reg, pend_next;

    logic                               emit;
    logic                               done;
    logic                               last;
    logic                               accept;
    logic [bud_pkg::HELD_W-1:0]         held_sub;
    logic [bud_pkg::CFG_DATA_W-1:0]     cnt_inc;
    logic [bud_pkg::BUF_BITS-1:0]       shifted;
    logic [bud_pkg::CODE_W-1:0]         code_mask;
    logic [bud_pkg::BUF_BITS-1:0]       buf_post;
    logic [bud_pkg::HELD_W-1:0]         held_post;
    logic [bud_pkg::CFG_DATA_W-1:0]     cnt_post;
    logic [bud_pkg::HELD_W:0]           held_add;

    always_comb
    begin
        held_sub  = held_reg - width;
        cnt_inc   = cnt_reg + 1'b1;
        done      = (cnt_inc == value_count);
        shifted   = buf_reg >> held_sub;
        code_mask = bud_pkg::CODE_W'((17'd1 << width) - 17'd1);
        emit      = pend_reg && !q_full;
        last      = done || (held_sub < width) ||
                    (n_reg == bud_pkg::BYTE_CNT_W'(bud_pkg::CODES_PER_BYTE - 1));
        full      = pend_reg && !(emit && last);
        accept    = push && !full;

        q_push                = emit;
        q_entry.code          = shifted[bud_pkg::CODE_W-1:0] & code_mask;
        q_entry.last_in_byte  = last;
        q_entry.stream_end    = done;

        // state after this cycle's code leaves
        buf_post  = buf_reg;
        held_post = held_reg;
        cnt_post  = cnt_reg;
        n_next    = n_reg;
        pend_next = pend_reg;
        if (emit)
        begin
            cnt_post  = cnt_inc;
            n_next    = n_reg + 1'b1;
            pend_next = !last;
            if (done)
            begin
                buf_post  = '0;
                held_post = '0;
            end
            else
            begin
                buf_post  = buf_reg &
                            bud_pkg::BUF_BITS'((24'd1 << held_sub) - 24'd1);
                held_post = held_sub;
            end
        end

        buf_next  = buf_post;
        held_next = held_post;
        cnt_next  = cnt_post;
        held_add  = {1'b0, held_post} + (bud_pkg::HELD_W+1)'(bud_pkg::BYTE_BITS);

        // bytes arriving after the stream is complete are dropped
        if (accept && (cnt_post < value_count))
        begin
            buf_next = bud_pkg::BUF_BITS'({buf_post, data_byte});
            if (held_add > (bud_pkg::HELD_W+1)'(bud_pkg::BUF_BITS))
            begin
                held_next = bud_pkg::HELD_W'(bud_pkg::BUF_BITS);
            end
            else
            begin
                held_next = held_add[bud_pkg::HELD_W-1:0];
            end
            n_next    = '0;
            pend_next = (held_next >= width);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg  <= '0;
            held_reg <= '0;
            cnt_reg  <= '0;
            n_reg    <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            buf_reg  <= buf_next;
            held_reg <= held_next;
            cnt_reg  <= cnt_next;
            n_reg    <= n_next;
            pend_reg <= pend_next;
        end
    end

endmodule

// ----- sv/bud_queue.sv -----
// Short queue of unpacked codes between front and back end.
// Depends on bud_pkg for the entry type.
module bud_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    output logic            wr_full,
    input  bud_pkg::entry_t wr_entry,
    output logic            rd_valid,
    input  logic            rd_en,
    output bud_pkg::entry_t rd_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bud_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr;
    logic             do_rd;

    always_comb
    begin
        wr_full  = (cnt_reg == CNT_W'(DEPTH));
        rd_valid = (cnt_reg != '0);
        rd_entry = mem_reg[rd_ptr_reg];
        do_wr    = wr_en && !wr_full;
        do_rd    = rd_en && rd_valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ----- sv/bud_back.sv -----
// Back end: scales each code by the step, adds the offset, and holds the
// result for the output side. Two register stages. Depends on bud_pkg.
module bud_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  bud_pkg::entry_t                   q_entry,
    input  bud_pkg::scale_cfg_t               scale,
    output logic                              empty,
    input  logic                              pop,
    output logic [bud_pkg::CODE_W-1:0]        code,
    output logic signed [bud_pkg::VALUE_W-1:0] value,
    output logic                              last_in_byte,
    output logic                              stream_end
);

    logic                               s1_valid_reg, s1_valid_next;
    logic [bud_pkg::PROD_W-1:0]         s1_prod_reg;
    bud_pkg::entry_t                    s1_entry_reg;
    logic                               out_valid_reg, out_valid_next;
    logic signed [bud_pkg::VALUE_W-1:0] value_reg, value_next;
    bud_pkg::entry_t                    out_entry_reg;

    logic out_ready;
    logic s1_ready;
    logic out_load;

    always_comb
    begin
        out_ready      = !out_valid_reg || pop;
        s1_ready       = !s1_valid_reg || out_ready;
        q_pop          = q_valid && s1_ready;
        out_load       = s1_valid_reg && out_ready;
        s1_valid_next  = s1_ready ? q_valid : s1_valid_reg;
        out_valid_next = out_ready ? s1_valid_reg : out_valid_reg;
        value_next     = $signed({{(bud_pkg::VALUE_W - bud_pkg::CFG_DATA_W)
                                   {scale.value_offset[bud_pkg::CFG_DATA_W-1]}},
                                  scale.value_offset}) +
                         $signed({{(bud_pkg::VALUE_W - bud_pkg::PROD_W){1'b0}},
                                  s1_prod_reg});

        empty        = !out_valid_reg;
        code         = out_entry_reg.code;
        value        = value_reg;
        last_in_byte = out_entry_reg.last_in_byte;
        stream_end   = out_entry_reg.stream_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_prod_reg  <= {{(bud_pkg::PROD_W - bud_pkg::CODE_W){1'b0}}, q_entry.code} *
                            {{(bud_pkg::PROD_W - bud_pkg::CFG_DATA_W){1'b0}},
                             scale.step_size};
            s1_entry_reg <= q_entry;
        end
        if (out_load)
        begin
            value_reg     <= value_next;
            out_entry_reg <= s1_entry_reg;
        end
    end

endmodule

// ----- sv/bit_unpack_uniform_dequantizer_top.sv -----
// Top level of the bit unpacking uniform dequantizer: settings registers,
// front end, code queue and back end. Depends on bud_pkg, bud_front,
// bud_queue and bud_back.
//
//   channel   ports                                      handshake
//   input     data_byte                                  push / full
//   result    code, value, last_in_byte, stream_end      pop / empty
//   settings  cfg_index, cfg_data                        cfg_valid / cfg_ready
//
// The unpacker splits out one code per cycle while the queue has room, and
// holds full while a byte still has codes to emit; full drops as the last
// code of the byte leaves, so the next byte can be taken as it leaves.
// The first code of a byte passes the bit buffer, the queue, the multiply
// stage and the add stage on its way to the result ports. cfg_ready is always high.
// Reset clears the bit buffer, the code count and all valid state;
// a stalled result side backs up through the queue to full.
module bit_unpack_uniform_dequantizer_top
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [7:0]                          data_byte,
    output logic                                empty,
    input  logic                                pop,
    output logic [15:0]                         code,
    output logic signed [49:0]                  value,
    output logic                                last_in_byte,
    output logic                                stream_end,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [31:0]                         cfg_data
);

    logic [bud_pkg::WIDTH_W-1:0]    code_width_reg;
    logic [bud_pkg::CFG_DATA_W-1:0] value_count_reg;
    logic [bud_pkg::CFG_DATA_W-1:0] value_offset_reg;
    logic [bud_pkg::CFG_DATA_W-1:0] step_size_reg;

    logic [bud_pkg::WIDTH_W-1:0]    width;
    bud_pkg::scale_cfg_t            scale;
    logic                           q_push;
    logic                           q_full;
    bud_pkg::entry_t                q_wr_entry;
    logic                           q_valid;
    logic                           q_pop;
    bud_pkg::entry_t                q_rd_entry;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_width_reg   <= bud_pkg::WIDTH_W'(8);
            value_count_reg  <= '0;
            value_offset_reg <= '0;
            step_size_reg    <= bud_pkg::CFG_DATA_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (bud_pkg::cfg_reg_t'(cfg_index))
                bud_pkg::REG_CODE_WIDTH:   code_width_reg   <= cfg_data[bud_pkg::WIDTH_W-1:0];
                bud_pkg::REG_VALUE_COUNT:  value_count_reg  <= cfg_data;
                bud_pkg::REG_VALUE_OFFSET: value_offset_reg <= cfg_data;
                bud_pkg::REG_STEP_SIZE:    step_size_reg    <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // zero width reads as one bit, anything above the maximum is clamped
    always_comb
    begin
        width = code_width_reg;
        if (code_width_reg == '0)
        begin
            width = bud_pkg::WIDTH_W'(1);
        end
        else if (code_width_reg > bud_pkg::WIDTH_W'(bud_pkg::MAX_CODE_WIDTH))
        begin
            width = bud_pkg::WIDTH_W'(bud_pkg::MAX_CODE_WIDTH);
        end
        scale.value_offset = value_offset_reg;
        scale.step_size    = step_size_reg;
    end

    bud_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .width       (width),
        .value_count (value_count_reg),
        .q_push      (q_push),
        .q_full      (q_full),
        .q_entry     (q_wr_entry)
    );

    bud_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_full  (q_full),
        .wr_entry (q_wr_entry),
        .rd_valid (q_valid),
        .rd_en    (q_pop),
        .rd_entry (q_rd_entry)
    );

    bud_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_entry      (q_rd_entry),
        .scale        (scale),
        .empty        (empty),
        .pop          (pop),
        .code         (code),
        .value        (value),
        .last_in_byte (last_in_byte),
        .stream_end   (stream_end)
    );

endmodule

// ----- sim/bit_unpack_uniform_dequantizer_top_test.sv -----
// Self-checking test for bit_unpack_uniform_dequantizer_top: a directed table, then
// random packed-code streams under three idle mixes, checked by a built-in unpacker model.
// Depends on bud_pkg and the block's RTL.
module bit_unpack_uniform_dequantizer_top_test;

    localparam int DRAIN_CYCLES = 12;
    localparam int QUIET_LIMIT  = 3000;
    localparam int ITEMS_PER_MIX = 50;
    localparam int MAX_PRINTS   = 40;

    typedef enum logic { ROW_CFG, ROW_BYTE } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        bud_pkg::cfg_reg_t idx;
        logic [31:0]       data;
        logic [7:0]        b;
        logic              typed;      // expectation written into the row
        logic              one_result; // typed rows give zero or one result
        logic [15:0]       t_code;
        logic [49:0]       t_value;
        logic              t_end;
    } stim_row_t;

    typedef struct packed {
        logic [15:0] code;
        logic [49:0] value;
        logic        last_in_byte;
        logic        stream_end;
    } dq_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] code;
    logic signed [49:0] value;
    logic        last_in_byte;
    logic        stream_end;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = bud_pkg::REG_CODE_WIDTH;
    logic [31:0] cfg_data = '0;

    // unpacker model: settings and state
    logic [4:0]  code_width_reg = 5'd8;
    logic [31:0] value_count_reg = '0;
    logic [31:0] offset_reg = '0;
    logic [31:0] step_reg = 32'h0001_0000;
    logic [22:0] bit_acc = '0;
    int unsigned acc_bits = 0;
    logic [31:0] codes_done = '0;

    dq_result_t byte_results[$];
    dq_result_t pending_results[$];
    dq_result_t head_result;
    stim_row_t  directed_rows[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    bit_unpack_uniform_dequantizer_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .empty        (empty),
        .pop          (pop),
        .code         (code),
        .value        (value),
        .last_in_byte (last_in_byte),
        .stream_end   (stream_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("MISMATCH: %s", msg);
    endtask

    // Unpack one byte into byte_results, updating the model state.
    function automatic void dequantize_byte(input logic [7:0] b);
        int unsigned w;
        logic [31:0] mask;
        logic [31:0] shifted;
        logic [15:0] c;
        logic [47:0] prod;
        dq_result_t r;
        int n;
        w = (code_width_reg == 0) ? 1 : ((code_width_reg > 16) ? 16 : code_width_reg);
        mask = (32'd1 << w) - 32'd1;
        n = 0;
        byte_results.delete();
        if (codes_done >= value_count_reg)
            return;
        bit_acc = {bit_acc[14:0], b};
        acc_bits = (acc_bits + 8 > 23) ? 23 : acc_bits + 8;
        while (acc_bits >= w && codes_done < value_count_reg && n < 8)
        begin
            shifted = {9'b0, bit_acc} >> (acc_bits - w);
            c = shifted[15:0] & mask[15:0];
            prod = {32'b0, c} * {16'b0, step_reg};
            acc_bits -= w;
            bit_acc = bit_acc & 23'((32'd1 << acc_bits) - 32'd1);
            codes_done++;
            r.code = c;
            r.value = {{18{offset_reg[31]}}, offset_reg} + {2'b0, prod};
            r.last_in_byte = 1'b0;
            r.stream_end = (codes_done == value_count_reg);
            byte_results.push_back(r);
            n++;
            if (codes_done == value_count_reg)
            begin
                bit_acc = '0;
                acc_bits = 0;
            end
        end
        if (n > 0)
            byte_results[n-1].last_in_byte = 1'b1;
    endfunction

    function automatic stim_row_t cfg_row(input bud_pkg::cfg_reg_t idx, input logic [31:0] d);
        stim_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.idx = idx;
        row.data = d;
        return row;
    endfunction

    function automatic stim_row_t byte_row(input logic [7:0] b);
        stim_row_t row;
        row = '0;
        row.kind = ROW_BYTE;
        row.b = b;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic [7:0] b, input logic one,
                                            input logic [15:0] c, input logic [49:0] v,
                                            input logic last_code);
        stim_row_t row;
        row = byte_row(b);
        row.typed = 1'b1;
        row.one_result = one;
        row.t_code = c;
        row.t_value = v;
        row.t_end = last_code;
        return row;
    endfunction

    task automatic write_reg(input bud_pkg::cfg_reg_t idx, input logic [31:0] d);
        push <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            bud_pkg::REG_CODE_WIDTH:   code_width_reg = d[4:0];
            bud_pkg::REG_VALUE_COUNT:  value_count_reg = d;
            bud_pkg::REG_VALUE_OFFSET: offset_reg = d;
            bud_pkg::REG_STEP_SIZE:    step_reg = d;
            default: ;
        endcase
    endtask

    task automatic send_byte(input stim_row_t row);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        cfg_valid <= 1'b0;
        data_byte <= row.b;
        do @(posedge clk); while (full);
        dequantize_byte(row.b);
        if (row.typed)
        begin
            byte_results.delete();
            if (row.one_result)
                byte_results.push_back({row.t_code, row.t_value, 1'b1, row.t_end});
        end
        foreach (byte_results[k])
            pending_results.push_back(byte_results[k]);
    endtask

    // All results in, then room for a byte that made no code to clear the front end.
    task automatic wait_idle();
        push <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result with none expected, code %h", code));
            else
            begin
                head_result = pending_results.pop_front();
                if (code !== head_result.code)
                    report_mismatch($sformatf("code %h, expected %h", code, head_result.code));
                if (value !== head_result.value)
                    report_mismatch($sformatf("value %0d, expected %0d (code %h)", value,
                                              $signed(head_result.value), head_result.code));
                if (last_in_byte !== head_result.last_in_byte)
                    report_mismatch($sformatf("last_in_byte %b, expected %b (code %h)",
                                              last_in_byte, head_result.last_in_byte,
                                              head_result.code));
                if (stream_end !== head_result.stream_end)
                    report_mismatch($sformatf("stream_end %b, expected %b (code %h)",
                                              stream_end, head_result.stream_end,
                                              head_result.code));
            end
        end
        pop <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int mix;
        int nvals;
        int cut;
        int sent;
        int random_items;
        bit broken;
        logic [31:0] pick;

        directed_rows = '{
            typed_row(8'hA5, 1'b0, 16'h0, 50'd0, 1'b0),      // nothing to emit after reset
            cfg_row(bud_pkg::REG_VALUE_COUNT, 32'd2),
            typed_row(8'h00, 1'b1, 16'h0000, 50'd0, 1'b0),
            typed_row(8'hFF, 1'b1, 16'h00FF, 50'd16711680, 1'b1),
            typed_row(8'h12, 1'b0, 16'h0, 50'd0, 1'b0),      // stream already finished
            cfg_row(bud_pkg::REG_CODE_WIDTH, 32'd16),
            cfg_row(bud_pkg::REG_VALUE_COUNT, 32'd3),
            cfg_row(bud_pkg::REG_VALUE_OFFSET, 32'h8000_0000),
            cfg_row(bud_pkg::REG_STEP_SIZE, 32'hFFFF_FFFF),
            typed_row(8'hFF, 1'b0, 16'h0, 50'd0, 1'b0),      // half a code only
            byte_row(8'hFF),
            cfg_row(bud_pkg::REG_CODE_WIDTH, 32'd0),         // zero width acts as one
            cfg_row(bud_pkg::REG_VALUE_COUNT, 32'hFFFF_FFFF),
            cfg_row(bud_pkg::REG_VALUE_OFFSET, 32'h7FFF_FFFF),
            cfg_row(bud_pkg::REG_STEP_SIZE, 32'd0),
            byte_row(8'hA5),                                 // eight codes from one byte
            cfg_row(bud_pkg::REG_CODE_WIDTH, 32'd31),        // clamps to 16
            cfg_row(bud_pkg::REG_VALUE_OFFSET, 32'd0),
            cfg_row(bud_pkg::REG_STEP_SIZE, 32'd1),
            typed_row(8'h80, 1'b0, 16'h0, 50'd0, 1'b0),
            typed_row(8'h01, 1'b1, 16'h8001, 50'd32769, 1'b0),
            cfg_row(bud_pkg::REG_CODE_WIDTH, 32'd3),
            byte_row(8'hFF),
            byte_row(8'h00),
            cfg_row(bud_pkg::REG_CODE_WIDTH, 32'd5),         // held bit reused at new width
            byte_row(8'h5A),
            cfg_row(bud_pkg::REG_VALUE_COUNT, 32'd19),
            byte_row(8'h3C),                                 // final code, padding dropped
            cfg_row(bud_pkg::REG_VALUE_COUNT, 32'd0),
            typed_row(8'h77, 1'b0, 16'h0, 50'd0, 1'b0)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 25;
        rx_idle_pct = 88;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                if (i == 0 || directed_rows[i-1].kind != ROW_CFG)
                    wait_idle();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end
            else
                send_byte(directed_rows[i]);
        end

        for (mix = 0; mix < 3; mix++)
        begin
            tx_idle_pct = (mix == 0) ? 25 : ((mix == 1) ? 88 : 0);
            rx_idle_pct = (mix == 0) ? 88 : ((mix == 1) ? 25 : 0);
            random_items = 0;
            while (random_items < ITEMS_PER_MIX)
            begin
                wait_idle();
                write_reg(bud_pkg::REG_CODE_WIDTH,
                          ($urandom_range(99) < 80) ? $urandom_range(1, 16)
                                                    : $urandom_range(0, 31));
                case ($urandom_range(0, 7))
                    0: pick = 32'h8000_0000;
                    1: pick = 32'h7FFF_FFFF;
                    2: pick = 32'd0;
                    default: pick = $urandom;
                endcase
                write_reg(bud_pkg::REG_VALUE_OFFSET, pick);
                case ($urandom_range(0, 7))
                    0: pick = 32'd0;
                    1: pick = 32'hFFFF_FFFF;
                    2: pick = 32'h0001_0000;
                    default: pick = $urandom;
                endcase
                write_reg(bud_pkg::REG_STEP_SIZE, pick);
                nvals = $urandom_range(1, 12);
                write_reg(bud_pkg::REG_VALUE_COUNT, codes_done + nvals);
                // a broken stream stops short and leaves bits behind for the next one
                broken = ($urandom_range(99) < 15);
                cut = $urandom_range(0, 3);
                sent = 0;
                while (codes_done < value_count_reg && !(broken && sent == cut))
                begin
                    if (sent > 0 && $urandom_range(99) < 8)
                    begin
                        wait_idle();
                        write_reg(bud_pkg::REG_CODE_WIDTH, $urandom_range(1, 16));
                    end
                    send_byte(byte_row(8'($urandom)));
                    sent++;
                    random_items++;
                end
                if ($urandom_range(99) < 10)
                    send_byte(byte_row(8'($urandom)));
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/bud_pkg.sv
sv/bud_front.sv
sv/bud_queue.sv
sv/bud_back.sv
sv/bit_unpack_uniform_dequantizer_top.sv
sim/bit_unpack_uniform_dequantizer_top_test.sv
